[hw/rtl/ilt_pkg.sv]
`timescale 1ns / 1ps

package ilt_pkg;

	// List geometry
	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam cnt_t CNT_DEPTH = cnt_t'(DEPTH);

	// Request opcodes
	typedef enum logic [2:0] {
		OP_APPEND    = 3'd0,
		OP_INSERT    = 3'd1,
		OP_REMOVE    = 3'd2,
		OP_READ      = 3'd3,
		OP_OVERWRITE = 3'd4
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [5:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [6:0]         entry_count;
	} rsp_t;

	// Store access for one cycle
	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		word_t wr_data;
	} mem_req_t;

	// Finished result from the sequencer
	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} fin_t;

endpackage

[hw/rtl/indexed_list_table.sv]
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------
// request  | req_valid, req_stall | req: opcode, position, value
// result   | rsp_valid, rsp_stall | rsp: status, read_value, entry_count
//
// One request at a time. Append, overwrite, failed requests and removal of the
// last entry finish without a store read; read goes through the registered store read.
// Insert moves the entries from the position up one place, any other remove moves
// those above it down one place: one entry moves per cycle through the store read and write.
// Reset empties the list at once; store contents stay undefined until written.
// A result waits in the output register under rsp_stall while the next request is taken in.

module indexed_list_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ilt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ilt_pkg::rsp_t rsp
);

	ilt_pkg::mem_req_t mem;
	ilt_pkg::word_t    rdata;
	ilt_pkg::fin_t     fin;
	logic              take;
	logic              rsp_valid_q;
	ilt_pkg::rsp_t     rsp_q;

	ilt_store u_store (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

	ilt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.take      (take),
		.fin       (fin),
		.mem       (mem),
		.rdata     (rdata)
	);

	// Load the output register when it is empty or being drained
	assign take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin.valid && take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid && take) begin
			rsp_q <= fin.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/ilt_store.sv]
`timescale 1ns / 1ps

module ilt_store (
	input  logic              clk,
	input  ilt_pkg::mem_req_t mem,
	output ilt_pkg::word_t    rdata
);

	ilt_pkg::word_t ram_q [ilt_pkg::DEPTH];
	ilt_pkg::word_t rdata_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			ram_q[mem.wr_addr] <= mem.wr_data;
		end
		if (mem.rd_en) begin
			rdata_q <= ram_q[mem.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ilt_seq.sv]
`timescale 1ns / 1ps

module ilt_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ilt_pkg::req_t     req,
	input  logic              take,
	output ilt_pkg::fin_t     fin,
	output ilt_pkg::mem_req_t mem,
	input  ilt_pkg::word_t    rdata
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_SHIFT_UP = 5'b00010,
		S_SHIFT_DN = 5'b00100,
		S_RD_WAIT  = 5'b01000,
		S_FINISH   = 5'b10000
	} state_t;

	state_t                 state_q, state_d;
	ilt_pkg::cnt_t          count_q, count_d;
	logic                   issue_q, issue_d;
	logic                   pend_s1, pend_d;
	ilt_pkg::addr_t         wa_s1, wa_d;
	ilt_pkg::addr_t         rd_addr_q, rd_addr_d;
	ilt_pkg::addr_t         pos_q, pos_d;
	ilt_pkg::word_t         val_q, val_d;
	ilt_pkg::status_t       status_q, status_d;
	ilt_pkg::word_t         rdval_q, rdval_d;
	ilt_pkg::opcode_t       req_op;
	logic                   occ;
	logic                   full;
	ilt_pkg::addr_t         last_addr;

	assign req_op    = ilt_pkg::opcode_t'(req.opcode);
	assign occ       = 32'(req.position) < 32'(count_q);
	assign full      = count_q == ilt_pkg::CNT_DEPTH;
	assign last_addr = ilt_pkg::addr_t'(ilt_pkg::cnt_t'(count_q - 1'b1));
	assign req_stall = state_q != S_IDLE;

	// Present the finished result
	always_comb begin
		fin                 = '0;
		fin.valid           = state_q == S_FINISH;
		fin.rsp.status      = status_q;
		fin.rsp.read_value  = rdval_q;
		fin.rsp.entry_count = 7'(count_q);
	end

	// Sequence each request through the store
	always_comb begin
		mem       = '0;
		state_d   = state_q;
		count_d   = count_q;
		issue_d   = issue_q;
		pend_d    = 1'b0;
		wa_d      = wa_s1;
		rd_addr_d = rd_addr_q;
		pos_d     = pos_q;
		val_d     = val_q;
		status_d  = status_q;
		rdval_d   = rdval_q;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					pos_d    = ilt_pkg::addr_t'(req.position);
					val_d    = req.value;
					rdval_d  = '0;
					status_d = ilt_pkg::ST_DONE;
					state_d  = S_FINISH;
					case (req_op)
						ilt_pkg::OP_APPEND: begin
							if (full) begin
								status_d = ilt_pkg::ST_FULL;
							end else begin
								mem.wr_en   = 1'b1;
								mem.wr_addr = ilt_pkg::addr_t'(count_q);
								mem.wr_data = req.value;
								count_d     = count_q + 1'b1;
							end
						end
						ilt_pkg::OP_INSERT: begin
							if (full) begin
								status_d = ilt_pkg::ST_FULL;
							end else if (!occ) begin
								status_d = ilt_pkg::ST_BADPOS;
							end else begin
								rd_addr_d = last_addr;
								issue_d   = 1'b1;
								state_d   = S_SHIFT_UP;
							end
						end
						ilt_pkg::OP_REMOVE: begin
							if (!occ) begin
								status_d = ilt_pkg::ST_BADPOS;
							end else if (32'(req.position) + 32'd1 < 32'(count_q)) begin
								rd_addr_d = ilt_pkg::addr_t'(req.position) + 1'b1;
								issue_d   = 1'b1;
								state_d   = S_SHIFT_DN;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						ilt_pkg::OP_READ: begin
							if (!occ) begin
								status_d = ilt_pkg::ST_BADPOS;
							end else begin
								mem.rd_en   = 1'b1;
								mem.rd_addr = ilt_pkg::addr_t'(req.position);
								state_d     = S_RD_WAIT;
							end
						end
						ilt_pkg::OP_OVERWRITE: begin
							if (!occ) begin
								status_d = ilt_pkg::ST_BADPOS;
							end else begin
								mem.wr_en   = 1'b1;
								mem.wr_addr = ilt_pkg::addr_t'(req.position);
								mem.wr_data = req.value;
							end
						end
						default: begin
							status_d = ilt_pkg::ST_BADPOS;
						end
					endcase
				end
			end
			S_SHIFT_UP: begin
				// Read downwards, write each word one place higher, then drop in the new word
				mem.rd_en   = issue_q;
				mem.rd_addr = rd_addr_q;
				pend_d      = issue_q;
				wa_d        = rd_addr_q + 1'b1;
				if (issue_q) begin
					if (rd_addr_q == pos_q) begin
						issue_d = 1'b0;
					end else begin
						rd_addr_d = rd_addr_q - 1'b1;
					end
				end
				if (pend_s1) begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = wa_s1;
					mem.wr_data = rdata;
				end else if (!issue_q) begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = pos_q;
					mem.wr_data = val_q;
					count_d     = count_q + 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_SHIFT_DN: begin
				// Read upwards, write each word one place lower
				mem.rd_en   = issue_q;
				mem.rd_addr = rd_addr_q;
				pend_d      = issue_q;
				wa_d        = rd_addr_q - 1'b1;
				if (issue_q) begin
					if (rd_addr_q == last_addr) begin
						issue_d = 1'b0;
					end else begin
						rd_addr_d = rd_addr_q + 1'b1;
					end
				end
				if (pend_s1) begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = wa_s1;
					mem.wr_data = rdata;
				end else if (!issue_q) begin
					count_d = count_q - 1'b1;
					state_d = S_FINISH;
				end
			end
			S_RD_WAIT: begin
				rdval_d = rdata;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			issue_q <= issue_d;
			pend_s1 <= pend_d;
		end
	end

	// Request payload and result fields
	always_ff @(posedge clk) begin
		wa_s1     <= wa_d;
		rd_addr_q <= rd_addr_d;
		pos_q     <= pos_d;
		val_q     <= val_d;
		status_q  <= status_d;
		rdval_q   <= rdval_d;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ilt_pkg::CNT_DEPTH)
		else $error("entry count beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
			|| count_q == $past(count_q) - 1'b1))
		else $error("entry count moved by more than one");

	a_pend_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_SHIFT_UP || state_q == S_SHIFT_DN))
		else $error("pending shift write outside a shift");

	a_up_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_UP && issue_q) |-> rd_addr_q >= pos_q)
		else $error("upward shift read below position");

	a_dn_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_DN && issue_q) |-> 32'(rd_addr_q) < 32'(count_q))
		else $error("downward shift read beyond last entry");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_UP && issue_q) |=> count_q == $past(count_q))
		else $error("entry count changed mid shift");

endmodule

[dv/indexed_list_table_tb.sv]
`timescale 1ns / 1ps

module indexed_list_table_tb;

	// Opcodes the block does not define
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// Mix of requests in the random part
	typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_t;

	// One line of the directed table; typed rows carry their own outcome
	typedef struct {
		ilt_pkg::req_t rq;
		int            times;
		bit            typed;
		ilt_pkg::rsp_t want;
	} stim_row_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	ilt_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	ilt_pkg::rsp_t rsp;

	// Shadow copy of the list contents and fill level
	ilt_pkg::word_t shadow_words [ilt_pkg::DEPTH];
	ilt_pkg::cnt_t  shadow_len;

	ilt_pkg::rsp_t outcome_q [$];
	stim_row_t     stim_rows [$];
	int            mismatch_count;
	int            result_seq;
	bit            req_calm;
	bit            rsp_calm;

	indexed_list_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 200)
			$display("mismatch at %0t ns, result %0d: %s", $time, result_seq, msg);
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one request to the shadow list and return its outcome
	function automatic ilt_pkg::rsp_t apply_list_op(input ilt_pkg::req_t r);
		ilt_pkg::rsp_t o;
		int            len;
		int            p;
		logic          held;
		len = shadow_len;
		p = r.position;
		held = (p < len);
		o = '0;
		o.status = ilt_pkg::ST_DONE;
		case (r.opcode)
			ilt_pkg::OP_APPEND: begin
				if (len >= ilt_pkg::DEPTH) begin
					o.status = ilt_pkg::ST_FULL;
				end else begin
					shadow_words[len] = r.value;
					len++;
				end
			end
			ilt_pkg::OP_INSERT: begin
				// full takes precedence over a bad position
				if (len >= ilt_pkg::DEPTH) begin
					o.status = ilt_pkg::ST_FULL;
				end else if (!held) begin
					o.status = ilt_pkg::ST_BADPOS;
				end else begin
					for (int i = len; i > p; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[p] = r.value;
					len++;
				end
			end
			ilt_pkg::OP_REMOVE: begin
				if (!held) begin
					o.status = ilt_pkg::ST_BADPOS;
				end else begin
					for (int i = p; i + 1 < len; i++)
						shadow_words[i] = shadow_words[i+1];
					len--;
				end
			end
			ilt_pkg::OP_READ: begin
				if (!held)
					o.status = ilt_pkg::ST_BADPOS;
				else
					o.read_value = shadow_words[p];
			end
			ilt_pkg::OP_OVERWRITE: begin
				if (!held)
					o.status = ilt_pkg::ST_BADPOS;
				else
					shadow_words[p] = r.value;
			end
			default: o.status = ilt_pkg::ST_BADPOS;
		endcase
		shadow_len = ilt_pkg::cnt_t'(len);
		o.entry_count = shadow_len;
		return o;
	endfunction

	function automatic void add_row(input logic [2:0] op, input int pos,
			input ilt_pkg::word_t val, input int times, input bit typed,
			input ilt_pkg::status_t st, input ilt_pkg::word_t rv, input int cnt);
		stim_row_t row;
		row.rq.opcode = op;
		row.rq.position = 6'(pos);
		row.rq.value = val;
		row.times = times;
		row.typed = typed;
		row.want.status = st;
		row.want.read_value = rv;
		row.want.entry_count = 7'(cnt);
		stim_rows.push_back(row);
	endfunction

	// Offer one request, hold it until taken, then record its outcome
	task automatic send_request(input ilt_pkg::req_t r, input bit typed,
			input ilt_pkg::rsp_t want);
		int            gap;
		ilt_pkg::rsp_t pred;
		gap = req_calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pred = apply_list_op(r);
		outcome_q.push_back(typed ? want : pred);
	endtask

	// Stall the result side in bursts, with quiet stretches
	initial begin
		int stall_left;
		int cyc;
		rsp_stall <= 1'b0;
		stall_left = 0;
		cyc = 0;
		rsp_calm = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 400 == 0)
				rsp_calm = !rsp_calm;
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (!rsp_calm)
					stall_left = pick_gap();
			end
		end
	end

	// Check each taken result against the oldest outcome
	always @(posedge clk) begin
		ilt_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (outcome_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result st=%0d rd=%h cnt=%0d",
					rsp.status, rsp.read_value, rsp.entry_count));
			end else begin
				want = outcome_q.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						rsp.status, want.status));
				if (rsp.read_value !== want.read_value)
					report_mismatch($sformatf("read_value %h, want %h",
						rsp.read_value, want.read_value));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						rsp.entry_count, want.entry_count));
			end
			result_seq++;
		end
	end

	initial begin
		stim_row_t     row;
		ilt_pkg::req_t r;
		ilt_pkg::rsp_t none;
		mix_t          mix;
		logic [2:0]    op;
		int            roll;
		int            len;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		mismatch_count = 0;
		result_seq = 0;
		req_calm = 1'b0;
		none = '0;

		// Empty list: every indexed request is a bad position
		add_row(ilt_pkg::OP_READ, 0, 32'h0, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 0);
		add_row(ilt_pkg::OP_REMOVE, 0, 32'h0, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 0);
		add_row(ilt_pkg::OP_INSERT, 0, 32'h1234_5678, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 0);
		add_row(ilt_pkg::OP_OVERWRITE, 0, 32'hFFFF_FFFF, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 0);
		// Extreme words in and back out
		add_row(ilt_pkg::OP_APPEND, 0, 32'h7FFF_FFFF, 1, 1, ilt_pkg::ST_DONE, 32'h0, 1);
		add_row(ilt_pkg::OP_APPEND, 63, 32'h8000_0000, 1, 1, ilt_pkg::ST_DONE, 32'h0, 2);
		add_row(ilt_pkg::OP_READ, 0, 32'h0, 1, 1, ilt_pkg::ST_DONE, 32'h7FFF_FFFF, 2);
		add_row(ilt_pkg::OP_READ, 1, 32'h0, 1, 1, ilt_pkg::ST_DONE, 32'h8000_0000, 2);
		add_row(ilt_pkg::OP_READ, 2, 32'h0, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 2);
		// Insert at the end is refused
		add_row(ilt_pkg::OP_INSERT, 2, 32'h0000_0001, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 2);
		add_row(ilt_pkg::OP_INSERT, 1, 32'hFFFF_FFFF, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_INSERT, 0, 32'h0000_0000, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_OVERWRITE, 3, 32'h5A5A_5A5A, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_READ, 63, 32'h0, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 4);
		add_row(ilt_pkg::OP_REMOVE, 0, 32'h0, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		// Undefined opcodes change nothing
		add_row(OP_UNUSED_LO, 0, 32'h0, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 3);
		add_row(OP_UNUSED_HI, 63, 32'hFFFF_FFFF, 1, 1, ilt_pkg::ST_BADPOS, 32'h0, 3);
		add_row(ilt_pkg::OP_READ, 1, 32'h0, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_REMOVE, 2, 32'h0, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		// Fill to the top, then hit full on append and insert
		add_row(ilt_pkg::OP_APPEND, 0, 32'h1000_0000, ilt_pkg::DEPTH - 2, 0,
			ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_APPEND, 0, 32'h2222_2222, 1, 1, ilt_pkg::ST_FULL, 32'h0,
			ilt_pkg::DEPTH);
		add_row(ilt_pkg::OP_INSERT, 63, 32'h3333_3333, 1, 1, ilt_pkg::ST_FULL, 32'h0,
			ilt_pkg::DEPTH);
		add_row(ilt_pkg::OP_READ, 63, 32'h0, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_OVERWRITE, 63, 32'h0000_0001, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		// Longest shifts in both directions
		add_row(ilt_pkg::OP_REMOVE, 0, 32'h0, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_INSERT, 0, 32'hDEAD_BEEF, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_REMOVE, 63, 32'h0, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);
		add_row(ilt_pkg::OP_READ, 62, 32'h0, 1, 0, ilt_pkg::ST_DONE, 32'h0, 0);

		shadow_len = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			for (int k = 0; k < row.times; k++) begin
				r = row.rq;
				r.value = row.rq.value + k;
				send_request(r, row.typed, row.want);
			end
		end

		// Random part: grow, churn, drain and churn again in turn
		for (int n = 0; n < 2000; n++) begin
			req_calm = ((n / 150) % 3 == 2);
			case ((n / 100) % 4)
				0:       mix = MIX_GROW;
				2:       mix = MIX_SHRINK;
				default: mix = MIX_BALANCED;
			endcase
			roll = $urandom_range(99);
			case (mix)
				MIX_GROW: begin
					if (roll < 50)      op = ilt_pkg::OP_APPEND;
					else if (roll < 85) op = ilt_pkg::OP_INSERT;
					else if (roll < 92) op = ilt_pkg::OP_READ;
					else if (roll < 97) op = ilt_pkg::OP_OVERWRITE;
					else                op = ilt_pkg::OP_REMOVE;
				end
				MIX_SHRINK: begin
					if (roll < 75)      op = ilt_pkg::OP_REMOVE;
					else if (roll < 80) op = ilt_pkg::OP_APPEND;
					else if (roll < 90) op = ilt_pkg::OP_READ;
					else                op = ilt_pkg::OP_OVERWRITE;
				end
				default: begin
					if (roll < 20)      op = ilt_pkg::OP_APPEND;
					else if (roll < 40) op = ilt_pkg::OP_INSERT;
					else if (roll < 60) op = ilt_pkg::OP_REMOVE;
					else if (roll < 80) op = ilt_pkg::OP_READ;
					else                op = ilt_pkg::OP_OVERWRITE;
				end
			endcase
			// Sprinkle undefined opcodes
			if ($urandom_range(99) < 3)
				op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			r.opcode = op;
			// Aim mostly at occupied entries
			len = shadow_len;
			if (len > 0 && $urandom_range(99) < 85)
				r.position = 6'($urandom_range(len - 1));
			else
				r.position = 6'($urandom_range(63));
			roll = $urandom_range(99);
			if (roll < 3)      r.value = 32'h8000_0000;
			else if (roll < 6) r.value = 32'h7FFF_FFFF;
			else               r.value = $urandom;
			send_request(r, 1'b0, none);
		end
		req_valid <= 1'b0;

		// Drain, then allow for stray results
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatch_count == 0 && outcome_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Stop a hung run
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

[files.f]
hw/rtl/ilt_pkg.sv
hw/rtl/ilt_store.sv
hw/rtl/ilt_seq.sv
hw/rtl/indexed_list_table.sv
dv/indexed_list_table_tb.sv
